// ===== rtl/core/qxmm_pkg.sv =====
// Shared types and constants for the quad X-frame motor mixer.
package qxmm_pkg;

  // Motor count and field widths.
  localparam int MOTOR_COUNT = 4;
  localparam int DUTY_W     = 13;
  localparam int DEMAND_W   = 16;
  localparam int CFG_IDX_W  = 3;

  // Doubled demand plus offset, duty span, product and accumulator widths.
  localparam int DEM_W      = DEMAND_W + 3;
  localparam int SPAN_W     = DUTY_W + 1;
  localparam int PROD_W     = DEM_W + SPAN_W;
  localparam int ACC_W      = 36;
  localparam int FRAC_SHIFT = 16;
  localparam int QUOT_W     = ACC_W - FRAC_SHIFT;

  // Offset that moves the doubled demand from -1..1 onto 0..2.
  localparam int DEMAND_HALF = 32768;

  // Register map: minimum duties first, then maximum duties.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BASE = 3'd4;

  // Reset values and saturation limit of a duty.
  localparam logic [DUTY_W-1:0] MIN_DUTY_RESET = 13'd0;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 13'd4096;
  localparam logic [DUTY_W-1:0] DUTY_SAT       = 13'h1FFF;

  // Item kinds.
  localparam logic KIND_MIX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  // Per-motor sign of each demand term in the X mix (bit i is motor i, 1 subtracts).
  localparam logic [MOTOR_COUNT-1:0] YAW_NEG   = 4'b1010;
  localparam logic [MOTOR_COUNT-1:0] PITCH_NEG = 4'b0110;
  localparam logic [MOTOR_COUNT-1:0] ROLL_NEG  = 4'b0011;

  typedef logic        [DUTY_W-1:0]   duty_t;
  typedef logic signed [DEMAND_W-1:0] demand_t;
  typedef logic signed [DEM_W-1:0]    dem_t;
  typedef logic signed [SPAN_W-1:0]   span_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;

endpackage

// ===== rtl/core/qxmm_if.sv =====
// Handshake interfaces for the mixer's demand and duty channels.
interface qxmm_in_if
  import qxmm_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    kind;
  demand_t throttle;
  demand_t roll;
  demand_t pitch;
  demand_t yaw;

  modport source (output valid, kind, throttle, roll, pitch, yaw, input ready);
  modport sink   (input valid, kind, throttle, roll, pitch, yaw, output ready);
endinterface

interface qxmm_out_if
  import qxmm_pkg::*;
();
  logic  valid;
  logic  ready;
  duty_t duty_front0;
  duty_t duty_front1;
  duty_t duty_rear2;
  duty_t duty_rear3;
  logic  limit_hit;

  modport source (output valid, duty_front0, duty_front1, duty_rear2, duty_rear3, limit_hit,
                  input ready);
  modport sink   (input valid, duty_front0, duty_front1, duty_rear2, duty_rear3, limit_hit,
                  output ready);
endinterface

// ===== rtl/core/quad_x_motor_mixer_unit.sv =====
// Top level of the quad X-frame motor mixer: mix, map, limit and clamp four duties.
//
//   channel   direction  content
//   in_ch     in         kind, throttle, roll, pitch, yaw (Q2.14)
//   out_ch    out        four motor duties (1/4096 units), limit_hit
//   cfg       in         cfg_we, cfg_index, cfg_data: min and max duty per motor
//
// One item is taken per cycle while no stall holds the input; each result passes through
// the input register, then mix and multiply, excess lowering, and shortfall raise with
// clamp, each into its own register, before it is offered.
// Each stage holds its item while the next one cannot load, so a stall at the output
// backs up one stage at a time and the input keeps taking items while bubbles remain.
// Synchronous reset clears the stage valid flags and restores the minimum and maximum duty registers.
module quad_x_motor_mixer_unit
  import qxmm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  qxmm_in_if.sink              in_ch,
  qxmm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  duty_t                cfg_data
);

  // Configuration registers.
  duty_t min_duty [MOTOR_COUNT];
  duty_t max_duty [MOTOR_COUNT];

  // Pipeline registers.
  logic    s1_valid, s2_valid, s3_valid, o_valid;
  logic    s1_kind, s2_kind, s3_kind;
  demand_t s1_throttle, s1_roll, s1_pitch, s1_yaw;
  acc_t    s2_v [MOTOR_COUNT];
  acc_t    s3_v [MOTOR_COUNT];
  duty_t   o_duty [MOTOR_COUNT];
  logic    o_hit;

  // Next values of the payload registers.
  acc_t    s2_v_next [MOTOR_COUNT];
  acc_t    s3_v_next [MOTOR_COUNT];
  duty_t   o_duty_next [MOTOR_COUNT];
  logic    o_hit_next;

  // Full-scale bounds of each motor in accumulator units.
  acc_t    lo [MOTOR_COUNT];
  acc_t    hi [MOTOR_COUNT];

  logic o_free, s3_free, s2_free, s1_free;

  // Larger of two signed accumulator values.
  function automatic acc_t acc_max(input acc_t a, input acc_t b);
    acc_max = (a > b) ? a : b;
  endfunction

  // A stage may load when it is empty or its item moves on in this cycle.
  assign o_free  = !o_valid  || out_ch.ready;
  assign s3_free = !s3_valid || o_free;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign in_ch.ready = s1_free;

  // Configuration writes: low half of the map is minimums, high half maximums.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        min_duty[i] <= MIN_DUTY_RESET;
        max_duty[i] <= MAX_DUTY_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_MAX_BASE) begin
        min_duty[2'(cfg_index - CFG_MIN_BASE)] <= cfg_data;
      end else begin
        max_duty[2'(cfg_index - CFG_MAX_BASE)] <= cfg_data;
      end
    end
  end

  // Motor bounds scaled by 2^16.
  always_comb begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      lo[i] = acc_t'({min_duty[i], {FRAC_SHIFT{1'b0}}});
      hi[i] = acc_t'({max_duty[i], {FRAC_SHIFT{1'b0}}});
    end
  end

  // Stage one: X mix of the doubled demands and linear map onto min..max.
  always_comb begin
    dem_t  t2, y2, pe, re, dd, dofs;
    span_t span;
    prod_t prod;
    t2 = dem_t'(s1_throttle) <<< 1;
    y2 = dem_t'(s1_yaw) <<< 1;
    pe = dem_t'(s1_pitch);
    re = dem_t'(s1_roll);
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      dd   = t2 + (YAW_NEG[i] ? -y2 : y2) + (PITCH_NEG[i] ? -pe : pe)
             + (ROLL_NEG[i] ? -re : re);
      dofs = dd + dem_t'(DEMAND_HALF);
      span = span_t'({1'b0, max_duty[i]}) - span_t'({1'b0, min_duty[i]});
      prod = dofs * span;
      s2_v_next[i] = lo[i] + acc_t'(prod);
    end
  end

  // Stage two: lower all motors by the largest excess over the maximum.
  always_comb begin
    acc_t ex [MOTOR_COUNT];
    acc_t adj;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      ex[i] = s2_v[i] - hi[i];
    end
    adj = acc_max(acc_max(ex[0], ex[1]), acc_max(ex[2], ex[3]));
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      s3_v_next[i] = (adj > 0) ? (s2_v[i] - adj) : s2_v[i];
    end
  end

  // Stage three: raise by the largest shortfall, clamp at the maximum, truncate.
  always_comb begin
    acc_t  sh [MOTOR_COUNT];
    acc_t  adj;
    acc_t  w;
    quot_t q;
    o_hit_next = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      sh[i] = lo[i] - s3_v[i];
    end
    adj = acc_max(acc_max(sh[0], sh[1]), acc_max(sh[2], sh[3]));
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      w = s3_v[i];
      if (adj > 0) begin
        w = s3_v[i] + adj;
        if (w > hi[i]) begin
          w = hi[i];
          o_hit_next = 1'b1;
        end
      end
      q = w[ACC_W-1:FRAC_SHIFT];
      if (q[QUOT_W-1]) begin
        o_duty_next[i] = '0;
      end else if (|q[QUOT_W-1:DUTY_W]) begin
        o_duty_next[i] = DUTY_SAT;
      end else begin
        o_duty_next[i] = q[DUTY_W-1:0];
      end
    end
    // A minimum item overrides the mix.
    if (s3_kind == KIND_MIN) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        o_duty_next[i] = min_duty[i];
      end
      o_hit_next = 1'b0;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= in_ch.valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (o_free)  o_valid  <= s3_valid;
    end
  end

  // Stage payloads load on each transfer into the stage.
  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_kind     <= in_ch.kind;
      s1_throttle <= in_ch.throttle;
      s1_roll     <= in_ch.roll;
      s1_pitch    <= in_ch.pitch;
      s1_yaw      <= in_ch.yaw;
    end
    if (s2_free && s1_valid) begin
      s2_kind <= s1_kind;
      s2_v    <= s2_v_next;
    end
    if (s3_free && s2_valid) begin
      s3_kind <= s2_kind;
      s3_v    <= s3_v_next;
    end
    if (o_free && s3_valid) begin
      o_duty <= o_duty_next;
      o_hit  <= o_hit_next;
    end
  end

  // Result channel.
  assign out_ch.valid       = o_valid;
  assign out_ch.duty_front0 = o_duty[0];
  assign out_ch.duty_front1 = o_duty[1];
  assign out_ch.duty_rear2  = o_duty[2];
  assign out_ch.duty_rear3  = o_duty[3];
  assign out_ch.limit_hit   = o_hit;

endmodule
